// File: rtl/core/multi_stage_envelope_player_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the envelope player
// Concurrent checks that compile away in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef MULTI_STAGE_ENVELOPE_PLAYER_TOP_DEFINES_SVH
`define MULTI_STAGE_ENVELOPE_PLAYER_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define MSENV_CHK_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define MSENV_CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define MSENV_CHK_NOW(lbl, ante, cons, msg)
`define MSENV_CHK_NEXT(lbl, ante, cons, msg)

`endif

`endif

// File: rtl/core/msenv_pkg.sv
// ----------------------------------------------------------------------------
// msenv_pkg
// Shared constants, codes, table lookups and control structs for the
// multi-stage envelope player.
// ----------------------------------------------------------------------------
`default_nettype none

package msenv_pkg;

  // Parameter defaults
  localparam int STAGES_DEF  = 8;
  localparam int HOLDOFF_DEF = 4;

  // Field widths
  localparam int TIME_W     = 32;
  localparam int VAL_W      = 14;
  localparam int LEVEL_W    = 7;
  localparam int LEN_W      = 8;
  localparam int NUM_FIELDS = 8;
  localparam int LEVELS_W   = NUM_FIELDS * LEVEL_W;
  localparam int LENGTHS_W  = NUM_FIELDS * LEN_W;
  localparam int POS_W      = 4;
  localparam int IDX_W      = 5;
  localparam int HOLD_W     = 8;
  localparam int HELD_W     = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int SCALE_W    = 8;
  localparam int DUR_W      = LEN_W + SCALE_W;

  // Interpolation datapath widths
  localparam int PROD_W = VAL_W + TIME_W;      // ls * span
  localparam int NUM_W  = PROD_W + 2;          // signed numerator
  localparam int REM_W  = NUM_W - 1;
  localparam int DVS_W  = TIME_W + VAL_W - 1;  // span << 13
  localparam int DIV_STEPS = VAL_W;
  localparam int CNT_W  = $clog2(DIV_STEPS);

  // Event codes
  localparam logic [1:0] FUNC_TICK    = 2'd0;
  localparam logic [1:0] FUNC_ON      = 2'd1;
  localparam logic [1:0] FUNC_OFF     = 2'd2;
  localparam logic [1:0] FUNC_RESTART = 2'd3;

  // Play modes
  localparam logic [1:0] MODE_GATED  = 2'd0;
  localparam logic [1:0] MODE_TRIG   = 2'd1;
  localparam logic [1:0] MODE_LOOPED = 2'd2;
  localparam logic [1:0] MODE_FREE   = 2'd3;

  // Control types with 7-bit resolution
  localparam logic [2:0] CT_CC = 3'd1;
  localparam logic [2:0] CT_PC = 3'd4;
  localparam logic [2:0] CT_AT = 3'd6;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLOCKED = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CTYPE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LEVELS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTHS = 3'd4;

  // Misc constants
  localparam logic [LEN_W-1:0]   LEN_END       = 8'd255;
  localparam logic [SCALE_W-1:0] SCALE_CLOCKED = 8'd3;
  localparam logic [SCALE_W-1:0] SCALE_TICKS   = 8'd195;
  localparam logic [VAL_W-1:0]   VAL_MAX       = 14'd16383;
  localparam logic [HELD_W-1:0]  HELD_MAX      = 8'd255;
  localparam logic [2:0]         CTYPE_RESET   = CT_CC;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;
    logic pre;
    logic mul1;
    logic mul2;
    logic chk;
    logic div_step;
    logic fin;
    logic load_out;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic pre_emit;
    logic pre_interp;
    logic chk_special;
    logic fin_emit;
    logic out_free;
  } status_t;

  // Stage level; stages past the register read as zero
  function automatic logic [LEVEL_W-1:0] level_of(input logic [LEVELS_W-1:0] levels,
                                                  input logic [IDX_W-1:0] idx);
    logic [LEVEL_W-1:0] r;
    r = '0;
    if (idx < IDX_W'(NUM_FIELDS)) r = levels[idx[2:0]*LEVEL_W +: LEVEL_W];
    return r;
  endfunction

  // Stage length; stages past the register read as end marker
  function automatic logic [LEN_W-1:0] length_of(input logic [LENGTHS_W-1:0] lengths,
                                                 input logic [IDX_W-1:0] idx);
    logic [LEN_W-1:0] r;
    r = LEN_END;
    if (idx < IDX_W'(NUM_FIELDS)) r = lengths[idx[2:0]*LEN_W +: LEN_W];
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/msenv_ctrl.sv
// ----------------------------------------------------------------------------
// msenv_ctrl
// Sequencer: takes a word, runs evaluation, then for interpolation the two
// multiply steps, the range check, the restoring divide (skipped on a special
// case) and the final compare; a result goes on to the output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "multi_stage_envelope_player_top_defines.svh"

module msenv_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  output logic                   item_stall,
  output msenv_pkg::cmd_t        cmd,
  input  wire msenv_pkg::status_t st
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PRE  = 3'd1;
  localparam logic [2:0] S_MUL1 = 3'd2;
  localparam logic [2:0] S_MUL2 = 3'd3;
  localparam logic [2:0] S_CHK  = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;
  localparam logic [2:0] S_EMIT = 3'd7;

  localparam logic [msenv_pkg::CNT_W-1:0] DIV_LAST =
    msenv_pkg::CNT_W'(msenv_pkg::DIV_STEPS - 1);

  logic [2:0]                    state, state_next;
  logic [msenv_pkg::CNT_W-1:0]   cnt, cnt_next;

  assign item_stall = (state != S_IDLE);

  // Next state and commands
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.accept = 1'b1;
          state_next = S_PRE;
        end
      end
      S_PRE: begin
        cmd.pre = 1'b1;
        if (st.pre_emit)        state_next = S_EMIT;
        else if (st.pre_interp) state_next = S_MUL1;
        else                    state_next = S_IDLE;
      end
      S_MUL1: begin
        cmd.mul1   = 1'b1;
        state_next = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2   = 1'b1;
        state_next = S_CHK;
      end
      S_CHK: begin
        cmd.chk = 1'b1;
        if (st.chk_special) begin
          state_next = S_FIN;
        end else begin
          state_next = S_DIV;
          cnt_next   = DIV_LAST;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt == '0) state_next = S_FIN;
        else           cnt_next   = cnt - 1'b1;
      end
      S_FIN: begin
        cmd.fin = 1'b1;
        if (st.fin_emit) state_next = S_EMIT;
        else             state_next = S_IDLE;
      end
      S_EMIT: begin
        if (st.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  `MSENV_CHK_NEXT(a_accept_to_pre, (state == S_IDLE) && item_valid, state == S_PRE, "accepted word did not start evaluation")
  `MSENV_CHK_NEXT(a_div_to_fin, (state == S_DIV) && (cnt == '0), state == S_FIN, "divide did not finish after last step")
  `MSENV_CHK_NEXT(a_emit_waits, (state == S_EMIT) && !st.out_free, state == S_EMIT, "result dropped while output busy")

endmodule

`default_nettype wire

// File: rtl/core/msenv_dp.sv
// ----------------------------------------------------------------------------
// msenv_dp
// Datapath: configuration registers, envelope state, stage transitions,
// interpolation multiply, restoring divider and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module msenv_dp #(
  parameter int STAGES  = msenv_pkg::STAGES_DEF,
  parameter int HOLDOFF = msenv_pkg::HOLDOFF_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // configuration
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [msenv_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [msenv_pkg::CFG_DATA_W-1:0]    cfg_data,
  // input word payload
  input  wire logic [1:0]                          func,
  input  wire logic [msenv_pkg::TIME_W-1:0]        now_time,
  // result channel
  output logic                                     result_valid,
  input  wire logic                                result_stall,
  output logic [msenv_pkg::VAL_W-1:0]              control_value,
  output logic [2:0]                               stage_index,
  // sequencer
  input  wire msenv_pkg::cmd_t                     cmd,
  output msenv_pkg::status_t                       st
);

  localparam int TW = msenv_pkg::TIME_W;
  localparam int VW = msenv_pkg::VAL_W;
  localparam int IW = msenv_pkg::IDX_W;
  localparam int LW = msenv_pkg::LEVEL_W;

  localparam logic [IW-1:0] STG_N    = IW'(STAGES);
  localparam logic [IW-1:0] STG_LAST = IW'(STAGES - 1);
  localparam logic [msenv_pkg::HOLD_W-1:0] HOLD_INIT = msenv_pkg::HOLD_W'(HOLDOFF);

  // Configuration
  logic [1:0]                         mode;
  logic                               clocked;
  logic [2:0]                         ctype;
  logic [msenv_pkg::LEVELS_W-1:0]     levels;
  logic [msenv_pkg::LENGTHS_W-1:0]    lengths;

  // Envelope state
  logic                               active;
  logic [msenv_pkg::POS_W-1:0]        pos;
  logic [TW-1:0]                      start_t;
  logic [TW-1:0]                      end_t;
  logic [VW-1:0]                      last;
  logic [msenv_pkg::HOLD_W-1:0]       holdoff;
  logic [msenv_pkg::HELD_W-1:0]       held;

  // Latched word and pending result stage
  logic [1:0]                         func_q;
  logic [TW-1:0]                      now_q;
  logic [2:0]                         pend_stage;

  // Interpolation registers
  logic [TW-1:0]                      span;
  logic [TW-1:0]                      elapsed;
  logic [VW-1:0]                      ls;
  logic [VW-1:0]                      le;
  logic [msenv_pkg::PROD_W-1:0]       prod1;
  logic signed [msenv_pkg::NUM_W-1:0] num;
  logic [msenv_pkg::REM_W-1:0]        rem;
  logic [msenv_pkg::DVS_W-1:0]        dvs;
  logic [VW-1:0]                      quo;

  // Evaluation logic
  logic                               restart, act0, act2;
  logic [msenv_pkg::HOLD_W-1:0]       hold0, hold1;
  logic [msenv_pkg::HELD_W-1:0]       held0, held2, held3;
  logic                               one_shot, looping;
  logic [IW-1:0]                      pos5, p_next, bidx, to5;
  logic                               do_start, do_live, past_end, end_shot, wrap;
  logic [TW-1:0]                      base_t;
  logic [msenv_pkg::SCALE_W-1:0]      scale;
  logic [msenv_pkg::DUR_W-1:0]        bdur;
  logic [LW-1:0]                      next_lvl, begin_lvl, from_lvl, to_lvl;

  // Multiply, check and divide logic
  logic signed [TW:0]                 el_s;
  logic signed [VW:0]                 diff;
  logic signed [msenv_pkg::NUM_W-1:0] term;
  logic [msenv_pkg::REM_W-1:0]        bound;
  logic [msenv_pkg::REM_W-1:0]        dvs_ext;
  logic                               q_bit;
  logic                               ct_trunc;
  logic [VW-1:0]                      vfin;

  assign cfg_ready = 1'b1;

  // Event handling, stage decision and status
  always_comb begin
    restart = (func_q == msenv_pkg::FUNC_RESTART);
    act0    = active & ~restart;
    hold0   = restart ? HOLD_INIT : holdoff;
    held0   = restart ? '0 : held;
    hold1   = (hold0 != '0) ? hold0 - 1'b1 : hold0;
    held2   = held0;
    act2    = act0;
    if (func_q == msenv_pkg::FUNC_OFF) begin
      if (held0 != '0) held2 = held0 - 1'b1;
      if (held2 == '0 && (mode == msenv_pkg::MODE_GATED || mode == msenv_pkg::MODE_LOOPED))
        act2 = 1'b0;
    end
    held3 = (func_q == msenv_pkg::FUNC_ON && held2 != msenv_pkg::HELD_MAX) ?
            held2 + 1'b1 : held2;

    one_shot = (mode == msenv_pkg::MODE_GATED || mode == msenv_pkg::MODE_TRIG);
    looping  = ~one_shot;
    pos5     = {1'b0, pos};
    p_next   = pos5 + 1'b1;

    do_start = ~act2 && (func_q == msenv_pkg::FUNC_ON || mode == msenv_pkg::MODE_FREE);
    do_live  = act2 && (hold1 == '0);
    past_end = (now_q >= end_t);
    end_shot = one_shot && (p_next == STG_LAST ||
               msenv_pkg::length_of(lengths, p_next) == msenv_pkg::LEN_END);
    wrap     = looping && (p_next >= STG_N ||
               msenv_pkg::length_of(lengths, p_next) == msenv_pkg::LEN_END);

    // Stage to begin and its timing
    bidx   = (do_start || wrap) ? '0 : p_next;
    base_t = do_start ? now_q : end_t;
    scale  = clocked ? msenv_pkg::SCALE_CLOCKED : msenv_pkg::SCALE_TICKS;
    bdur   = msenv_pkg::DUR_W'(msenv_pkg::length_of(lengths, bidx)) *
             msenv_pkg::DUR_W'(scale);

    // Interpolation target
    to5 = p_next;
    if (looping && (pos5 == STG_LAST ||
        msenv_pkg::length_of(lengths, p_next) == msenv_pkg::LEN_END))
      to5 = '0;
    if (to5 >= STG_N) to5 = '0;

    next_lvl  = msenv_pkg::level_of(levels, p_next);
    begin_lvl = msenv_pkg::level_of(levels, bidx);
    from_lvl  = msenv_pkg::level_of(levels, pos5);
    to_lvl    = msenv_pkg::level_of(levels, to5);

    st.pre_emit   = do_start || (do_live && past_end);
    st.pre_interp = ~do_start && do_live && ~past_end;

    // Numerator, range check and divide step
    el_s  = $signed({1'b0, elapsed});
    diff  = $signed({1'b0, le}) - $signed({1'b0, ls});
    term  = msenv_pkg::NUM_W'(el_s) * msenv_pkg::NUM_W'(diff);
    bound = {1'b0, span, {VW{1'b0}}};
    st.chk_special = (span == '0) || num[msenv_pkg::NUM_W-1] ||
                     (num[msenv_pkg::REM_W-1:0] >= bound);
    dvs_ext = {2'b00, dvs};
    q_bit   = (rem >= dvs_ext);
    ct_trunc = (ctype == msenv_pkg::CT_CC) || (ctype == msenv_pkg::CT_PC) ||
               (ctype == msenv_pkg::CT_AT);
    vfin = ct_trunc ? {quo[VW-1:LW], {LW{1'b0}}} : quo;
    st.fin_emit = (vfin != last);
    st.out_free = ~result_valid | ~result_stall;
  end

  // Configuration, envelope state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= msenv_pkg::MODE_GATED;
      clocked      <= 1'b0;
      ctype        <= msenv_pkg::CTYPE_RESET;
      levels       <= '0;
      lengths      <= '0;
      active       <= 1'b0;
      pos          <= '0;
      start_t      <= '0;
      end_t        <= '0;
      last         <= '0;
      holdoff      <= HOLD_INIT;
      held         <= '0;
      result_valid <= 1'b0;
    end else begin
      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          msenv_pkg::REG_MODE:    mode    <= cfg_data[1:0];
          msenv_pkg::REG_CLOCKED: clocked <= cfg_data[0];
          msenv_pkg::REG_CTYPE:   ctype   <= cfg_data[2:0];
          msenv_pkg::REG_LEVELS:  levels  <= cfg_data[msenv_pkg::LEVELS_W-1:0];
          msenv_pkg::REG_LENGTHS: lengths <= cfg_data[msenv_pkg::LENGTHS_W-1:0];
          default: ;
        endcase
      end

      // evaluation commit
      if (cmd.pre) begin
        held <= held3;
        if (st.pre_emit) begin
          holdoff <= HOLD_INIT;
          if (~do_start && end_shot) begin
            last   <= {next_lvl, {LW{1'b0}}};
            active <= 1'b0;
          end else begin
            active  <= 1'b1;
            pos     <= bidx[msenv_pkg::POS_W-1:0];
            last    <= {begin_lvl, {LW{1'b0}}};
            start_t <= base_t;
            end_t   <= base_t + TW'(bdur);
          end
        end else begin
          holdoff <= hold1;
          active  <= act2;
        end
      end

      // interpolated value changed
      if (cmd.fin && st.fin_emit) begin
        last    <= vfin;
        holdoff <= HOLD_INIT;
      end

      // output register
      if (cmd.load_out)                      result_valid <= 1'b1;
      else if (result_valid && !result_stall) result_valid <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      func_q <= func;
      now_q  <= now_time;
    end
    if (cmd.pre) begin
      if (~do_start && end_shot) pend_stage <= p_next[2:0];
      else                       pend_stage <= bidx[2:0];
      span    <= end_t - start_t;
      elapsed <= now_q - start_t;
      ls      <= {from_lvl, {LW{1'b0}}};
      le      <= {to_lvl, {LW{1'b0}}};
    end
    if (cmd.mul1) prod1 <= msenv_pkg::PROD_W'(ls) * msenv_pkg::PROD_W'(span);
    if (cmd.mul2) num   <= $signed({2'b00, prod1}) + term;
    if (cmd.chk) begin
      rem <= num[msenv_pkg::REM_W-1:0];
      dvs <= {span, {(VW-1){1'b0}}};
      if (span == '0)                                  quo <= le;
      else if (num[msenv_pkg::NUM_W-1])                quo <= '0;
      else if (num[msenv_pkg::REM_W-1:0] >= bound)     quo <= msenv_pkg::VAL_MAX;
      else                                             quo <= '0;
    end
    if (cmd.div_step) begin
      if (q_bit) rem <= rem - dvs_ext;
      quo <= {quo[VW-2:0], q_bit};
      dvs <= dvs >> 1;
    end
    if (cmd.fin && st.fin_emit) pend_stage <= pos[2:0];
    if (cmd.load_out) begin
      control_value <= last;
      stage_index   <= pend_stage;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/multi_stage_envelope_player_top.sv
// ----------------------------------------------------------------------------
// multi_stage_envelope_player_top
// Eight-stage level/length envelope player that sends a 14-bit controller
// value whenever the envelope output changes.
// ----------------------------------------------------------------------------
//
//  Channel  Signals                                   Direction  Handshake
//  -------  ----------------------------------------  ---------  ------------
//  item     item_valid item_stall func now_time       in         valid/stall
//  result   result_valid result_stall control_value   out        valid/stall
//           stage_index
//  cfg      cfg_valid cfg_ready cfg_index cfg_data    in         valid/ready
//
//  One word at a time. A word with no interpolation goes from evaluation
//  straight to the output register or back to idle; an interpolated word
//  runs the two multiply steps, the range check and the 14-step restoring
//  divider, which is skipped when the span is zero or the value clamps.
//  Reset is synchronous; no clearing pass is needed.
//  A result waits in the output register under result_stall while the next
//  word is taken; evaluation only pauses when a second result is ready.
//
`default_nettype none

module multi_stage_envelope_player_top #(
  parameter int STAGES  = msenv_pkg::STAGES_DEF,
  parameter int HOLDOFF = msenv_pkg::HOLDOFF_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [msenv_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [msenv_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                              item_valid,
  output logic                                   item_stall,
  input  wire logic [1:0]                        func,
  input  wire logic [msenv_pkg::TIME_W-1:0]      now_time,
  output logic                                   result_valid,
  input  wire logic                              result_stall,
  output logic [msenv_pkg::VAL_W-1:0]            control_value,
  output logic [2:0]                             stage_index
);

  msenv_pkg::cmd_t    cmd;
  msenv_pkg::status_t st;

  // Sequencer
  msenv_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .cmd        (cmd),
    .st         (st)
  );

  // Datapath
  msenv_dp #(
    .STAGES  (STAGES),
    .HOLDOFF (HOLDOFF)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .func          (func),
    .now_time      (now_time),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .control_value (control_value),
    .stage_index   (stage_index),
    .cmd           (cmd),
    .st            (st)
  );

endmodule

`default_nettype wire
